>>> hdl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg: shared definitions for the decimal ASCII converter
// Widths, character codes, controller states and the control group that the
// controller hands to the row of BCD digit cells.
// ----------------------------------------------------------------------------
package itda_pkg;

   // Width of the integer taken from each item.
   localparam int VALUE_WIDTH = 64;

   // Decimal digits needed for 2^VALUE_WIDTH - 1: floor(W * log10(2)) + 1,
   // with log10(2) approximated by 1233 / 4096.
   localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;

   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
   localparam int COUNT_WIDTH = $clog2(NUM_DIGITS);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef logic [3:0] bcd_digit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } itda_state_type;

   // Controls for every cell of the digit row; at most one is set per cycle.
   typedef struct packed {
      logic clear;      // load all digits with zero
      logic convert;    // one add-3-and-shift step of double dabble
      logic shift_out;  // move every digit one place toward the top cell
   } itda_chain_ctrl_type;

endpackage

>>> hdl/itda_bcd_cell.sv
// ----------------------------------------------------------------------------
// itda_bcd_cell: one BCD digit of the conversion row
// Holds a single decimal digit. Performs the double dabble adjust-and-shift
// step with its neighbor, or passes its digit up the row during output.
// ----------------------------------------------------------------------------
module itda_bcd_cell (
   input  logic                         clock,
   input  itda_pkg::itda_chain_ctrl_type ctrl,
   input  logic                         carry_in,
   input  itda_pkg::bcd_digit_type      digit_in,
   output itda_pkg::bcd_digit_type      digit,
   output logic                         carry_out
);
   import itda_pkg::*;

   bcd_digit_type digit_ff;
   bcd_digit_type digit_in_next;
   bcd_digit_type adjusted;

   // Digits of five or more gain three so the shift carries correctly.
   assign adjusted  = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign carry_out = adjusted[3];
   assign digit     = digit_ff;

   always_comb begin
      digit_in_next = digit_ff;
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.convert) begin
         digit_in_next = {adjusted[2:0], carry_in};
      end else if (ctrl.shift_out) begin
         digit_in_next = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

>>> hdl/itda_bcd_chain.sv
// ----------------------------------------------------------------------------
// itda_bcd_chain: row of BCD digit cells
// Cell zero holds the least significant digit and takes the serial binary
// bit; the top cell holds the most significant digit and feeds the output.
// ----------------------------------------------------------------------------
module itda_bcd_chain (
   input  logic                         clock,
   input  itda_pkg::itda_chain_ctrl_type ctrl,
   input  logic                         serial_in,
   output itda_pkg::bcd_digit_type      top_digit
);
   import itda_pkg::*;

   bcd_digit_type digits [NUM_DIGITS];
   logic          carries [NUM_DIGITS];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      logic          cell_carry_in;
      bcd_digit_type cell_digit_in;

      if (i == 0) begin : g_first
         assign cell_carry_in = serial_in;
         assign cell_digit_in = '0;
      end else begin : g_rest
         assign cell_carry_in = carries[i-1];
         assign cell_digit_in = digits[i-1];
      end

      itda_bcd_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .carry_in  (cell_carry_in),
         .digit_in  (cell_digit_in),
         .digit     (digits[i]),
         .carry_out (carries[i])
      );
   end

   assign top_digit = digits[NUM_DIGITS-1];

endmodule

>>> hdl/integer_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit: binary integer to decimal ASCII text
// Converts one integer per item into its decimal characters, sign first,
// most significant digit first, with leading zeros suppressed.
// ----------------------------------------------------------------------------
// Each accepted item holds a 64-bit value and a signed flag. The unit emits
// one result item per character: an optional '-' for a negative signed value,
// then the decimal digits with no leading zeros, the last one flagged by
// rsp_last_char. Zero prints as a single '0', and the most negative signed
// value prints its full magnitude. Conversion runs on a row of 20 BCD digit
// cells with the double dabble method: one input bit enters the row per
// cycle until every bit of the value is in. Output then walks the row from
// the top digit one position per cycle, but a digit to be printed waits
// while the output register is full and stalled; leading zero positions
// are passed over without an output item. One item is converted at a
// time: req_stall is high from acceptance until the final character has
// entered the output register, and that register lets the next item be
// taken while the final character still waits on rsp_stall.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value_bits,
   input  logic        req_is_signed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_ascii_char,
   output logic        rsp_last_char
);
   import itda_pkg::*;

   itda_state_type            state_ff, state_in;
   logic [VALUE_WIDTH-1:0]    mag_ff, mag_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;
   logic [COUNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic                      started_ff, started_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_char_ff, rsp_char_in;
   logic                      rsp_last_ff, rsp_last_in;

   itda_chain_ctrl_type       chain_ctrl;
   bcd_digit_type             top_digit;
   logic [VALUE_WIDTH-1:0]    value;
   logic                      value_neg;
   logic                      out_free;
   logic                      cnt_last;
   logic                      step_last;

   // The digit row. The binary magnitude leaves its top bit into cell zero.
   itda_bcd_chain u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .serial_in (mag_ff[VALUE_WIDTH-1]),
      .top_digit (top_digit)
   );

   // Only the low VALUE_WIDTH bits of the item count.
   assign value     = req_value_bits[VALUE_WIDTH-1:0];
   assign value_neg = req_is_signed & value[VALUE_WIDTH-1];

   // The output register can take a character when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_last  = (cnt_ff == COUNT_WIDTH'(NUM_DIGITS - 1));
   assign step_last = (step_ff == STEP_WIDTH'(VALUE_WIDTH - 1));

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      chain_ctrl   = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Two's complement negation gives the magnitude, including
               // the most negative value.
               mag_in           = value_neg ? (VALUE_WIDTH'(0) - value) : value;
               neg_in           = value_neg;
               step_in          = '0;
               chain_ctrl.clear = 1'b1;
               state_in         = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            chain_ctrl.convert = 1'b1;
            mag_in             = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            step_in            = step_ff + 1'b1;
            if (step_last) begin
               cnt_in     = '0;
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!started_ff && (top_digit == 4'd0) && !cnt_last) begin
               // Leading zero: pass over it without an output item.
               chain_ctrl.shift_out = 1'b1;
               cnt_in               = cnt_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_char_in          = CHAR_ZERO | {4'b0000, top_digit};
               rsp_last_in          = cnt_last;
               started_in           = 1'b1;
               chain_ctrl.shift_out = 1'b1;
               if (cnt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         started_ff   <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // An accepted item always starts conversion from the first bit.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONVERT && step_ff == '0))
      else $error("accepted item did not start conversion");

   // Conversion leaves after exactly the last bit, toward sign or digits.
   a_convert_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && step_last) |=>
         (state_ff == ST_SIGN || state_ff == ST_EMIT))
      else $error("conversion did not end after the last bit");

   // Double dabble must leave only valid decimal digits in the row.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (top_digit <= 4'd9))
      else $error("digit row holds a non-decimal digit");

   // A minus sign is never the final character of a number.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_char_ff == CHAR_MINUS) |-> !rsp_last_ff)
      else $error("minus sign flagged as last character");

endmodule
